@@ rtl/pdh_pkg.sv @@
package pdh_pkg;

  localparam int unsigned MaxBinsDefault = 1024;

  localparam int unsigned PosW   = 32;
  localparam int unsigned CountW = 32;
  localparam int unsigned IndexW = 10;
  localparam int unsigned WidthW = 31;
  localparam int unsigned NBinsW = 11;
  localparam int unsigned StepW  = 5;

  localparam int unsigned InDataW  = 112;
  localparam int unsigned OutDataW = 80;

  localparam logic [1:0] ReqAtom  = 2'd0;
  localparam logic [1:0] ReqFrame = 2'd1;
  localparam logic [1:0] ReqRead  = 2'd2;

  localparam logic [1:0] AxisX = 2'd0;
  localparam logic [1:0] AxisY = 2'd1;
  localparam logic [1:0] AxisZ = 2'd2;

  localparam logic [1:0] CfgAxisSelect = 2'd0;
  localparam logic [1:0] CfgBoxLow     = 2'd1;
  localparam logic [1:0] CfgBinWidth   = 2'd2;
  localparam logic [1:0] CfgBinCount   = 2'd3;

  typedef enum logic [2:0] {
    StClear,
    StIdle,
    StDiv,
    StCheck,
    StRead,
    StUpdate,
    StResult
  } pdh_state_e;

endpackage

@@ rtl/position_density_histogram_top.sv @@
// Steps from accept to result load: an atom runs 32 divider steps, limit check, memory read
// and update, skips read and update beyond the last bin and skips all below the box or with
// a zero bin width; a frame beat loads directly; a read beat reads unless past MAX_BINS.
// Throughput: one beat at a time; the next beat is taken the cycle after the result is loaded.
// Reset: asynchronous, active low; afterwards the bin memory is cleared one entry
// per cycle, all MAX_BINS entries, with s_axis_tready low; configuration is taken throughout.
module position_density_histogram_top #(
  parameter int unsigned MAX_BINS = pdh_pkg::MaxBinsDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,

  input  logic                          cfg_we_i,
  input  logic [1:0]                    cfg_index_i,
  input  logic [31:0]                   cfg_data_i,

  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // pos_x, pos_y, pos_z, read_index, zero fill
  input  logic [pdh_pkg::InDataW-1:0]   s_axis_tdata,
  // req_type
  input  logic [1:0]                    s_axis_tuser,

  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // bin_index, bin_value, frames_seen, zero fill
  output logic [pdh_pkg::OutDataW-1:0]  m_axis_tdata,
  // out_of_range
  output logic                          m_axis_tuser
);

  localparam int unsigned AddrW = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
  localparam logic [AddrW-1:0] LastAddr = AddrW'(MAX_BINS - 1);
  localparam logic [pdh_pkg::CountW-1:0] MaxBinsC = pdh_pkg::CountW'(MAX_BINS);
  localparam logic [pdh_pkg::CountW-1:0] CountMax = '1;

  pdh_pkg::pdh_state_e state_q, state_d;

  logic [1:0]                     axis_q, axis_d;
  logic [pdh_pkg::PosW-1:0]       box_low_q, box_low_d;
  logic [pdh_pkg::WidthW-1:0]     bin_pitch_q, bin_pitch_d;
  logic [pdh_pkg::NBinsW-1:0]     bin_count_q, bin_count_d;

  logic [1:0]                     req_q, req_d;
  logic [pdh_pkg::WidthW-1:0]     rem_q, rem_d;
  logic [pdh_pkg::CountW-1:0]     quot_q, quot_d;
  logic [pdh_pkg::StepW-1:0]      step_q, step_d;
  logic [AddrW-1:0]               addr_q, addr_d;
  logic [pdh_pkg::IndexW-1:0]     res_index_q, res_index_d;
  logic [pdh_pkg::CountW-1:0]     res_value_q, res_value_d;
  logic                           res_oor_q, res_oor_d;
  logic [pdh_pkg::CountW-1:0]     frame_q, frame_d;

  logic                           out_valid_q, out_valid_d;
  logic [pdh_pkg::IndexW-1:0]     out_index_q, out_index_d;
  logic [pdh_pkg::CountW-1:0]     out_value_q, out_value_d;
  logic [pdh_pkg::CountW-1:0]     out_frames_q, out_frames_d;
  logic                           out_oor_q, out_oor_d;

  logic [pdh_pkg::CountW-1:0]     mem [MAX_BINS];
  logic [pdh_pkg::CountW-1:0]     mem_rdata_q;
  logic                           mem_we;
  logic [pdh_pkg::CountW-1:0]     mem_wdata;

  logic                           in_accept;
  logic                           out_free;
  logic                           out_load;
  logic [1:0]                     req_in;
  logic [pdh_pkg::PosW-1:0]       pos_sel;
  logic [pdh_pkg::PosW:0]         diff;
  logic                           atom_drop;
  logic [pdh_pkg::IndexW-1:0]     read_index;
  logic [AddrW+pdh_pkg::IndexW-1:0] read_index_ext;
  logic                           read_beyond;
  logic [pdh_pkg::CountW-1:0]     trial;
  logic                           trial_ge;
  logic                           in_range;
  logic [pdh_pkg::CountW-1:0]     bin_inc;

  assign req_in     = s_axis_tuser;
  assign read_index = s_axis_tdata[105:96];
  assign in_accept  = s_axis_tvalid && s_axis_tready;
  assign out_free   = !out_valid_q || m_axis_tready;

  always_comb begin
    case (axis_q)
      pdh_pkg::AxisX: pos_sel = s_axis_tdata[31:0];
      pdh_pkg::AxisY: pos_sel = s_axis_tdata[63:32];
      pdh_pkg::AxisZ: pos_sel = s_axis_tdata[95:64];
      default:        pos_sel = '0;
    endcase
  end

  assign diff = {pos_sel[pdh_pkg::PosW-1], pos_sel}
              - {box_low_q[pdh_pkg::PosW-1], box_low_q};
  assign atom_drop = diff[pdh_pkg::PosW] || (bin_pitch_q == '0);

  assign read_index_ext = {{AddrW{1'b0}}, read_index};
  assign read_beyond    = {22'd0, read_index} >= MaxBinsC;

  assign trial    = {rem_q, quot_q[pdh_pkg::CountW-1]};
  assign trial_ge = trial >= {1'b0, bin_pitch_q};

  assign in_range = (quot_q < {21'd0, bin_count_q}) && (quot_q < MaxBinsC);
  assign bin_inc  = (mem_rdata_q == CountMax) ? mem_rdata_q : mem_rdata_q + 1'b1;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      pdh_pkg::StClear:  if (addr_q == LastAddr) state_d = pdh_pkg::StIdle;
      pdh_pkg::StIdle: begin
        if (in_accept) begin
          unique case (req_in)
            pdh_pkg::ReqAtom:  state_d = atom_drop ? pdh_pkg::StResult : pdh_pkg::StDiv;
            pdh_pkg::ReqFrame: state_d = pdh_pkg::StResult;
            pdh_pkg::ReqRead:  state_d = read_beyond ? pdh_pkg::StResult : pdh_pkg::StRead;
            default:           state_d = pdh_pkg::StIdle;
          endcase
        end
      end
      pdh_pkg::StDiv:    if (step_q == '0) state_d = pdh_pkg::StCheck;
      pdh_pkg::StCheck:  state_d = in_range ? pdh_pkg::StRead : pdh_pkg::StResult;
      pdh_pkg::StRead:   state_d = pdh_pkg::StUpdate;
      pdh_pkg::StUpdate: state_d = pdh_pkg::StResult;
      pdh_pkg::StResult: if (out_free) state_d = pdh_pkg::StIdle;
      default:           state_d = pdh_pkg::StIdle;
    endcase
  end

  // state outputs
  always_comb begin
    s_axis_tready = 1'b0;
    mem_we        = 1'b0;
    mem_wdata     = bin_inc;
    out_load      = 1'b0;
    unique case (state_q)
      pdh_pkg::StClear: begin
        mem_we    = 1'b1;
        mem_wdata = '0;
      end
      pdh_pkg::StIdle:   s_axis_tready = 1'b1;
      pdh_pkg::StUpdate: mem_we = (req_q == pdh_pkg::ReqAtom);
      pdh_pkg::StResult: out_load = out_free;
      default: ;
    endcase
  end

  // configuration
  always_comb begin
    axis_d      = axis_q;
    box_low_d   = box_low_q;
    bin_pitch_d = bin_pitch_q;
    bin_count_d = bin_count_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        pdh_pkg::CfgAxisSelect: axis_d      = cfg_data_i[1:0];
        pdh_pkg::CfgBoxLow:     box_low_d   = cfg_data_i;
        pdh_pkg::CfgBinWidth:   bin_pitch_d = cfg_data_i[pdh_pkg::WidthW-1:0];
        pdh_pkg::CfgBinCount:   bin_count_d = cfg_data_i[pdh_pkg::NBinsW-1:0];
        default: ;
      endcase
    end
  end

  // datapath
  always_comb begin
    req_d       = req_q;
    rem_d       = rem_q;
    quot_d      = quot_q;
    step_d      = step_q;
    addr_d      = addr_q;
    res_index_d = res_index_q;
    res_value_d = res_value_q;
    res_oor_d   = res_oor_q;
    frame_d     = frame_q;
    case (state_q)
      pdh_pkg::StClear: addr_d = addr_q + 1'b1;
      pdh_pkg::StIdle: begin
        if (in_accept) begin
          req_d       = req_in;
          res_index_d = '0;
          res_value_d = '0;
          res_oor_d   = 1'b0;
          case (req_in)
            pdh_pkg::ReqAtom: begin
              res_oor_d = atom_drop;
              rem_d     = '0;
              quot_d    = diff[pdh_pkg::CountW-1:0];
              step_d    = '1;
            end
            pdh_pkg::ReqFrame: if (frame_q != CountMax) frame_d = frame_q + 1'b1;
            pdh_pkg::ReqRead: begin
              res_index_d = read_index;
              addr_d      = read_index_ext[AddrW-1:0];
            end
            default: ;
          endcase
        end
      end
      pdh_pkg::StDiv: begin
        rem_d  = trial_ge ? 31'(trial - {1'b0, bin_pitch_q}) : trial[pdh_pkg::WidthW-1:0];
        quot_d = {quot_q[pdh_pkg::CountW-2:0], trial_ge};
        step_d = step_q - 1'b1;
      end
      pdh_pkg::StCheck: begin
        if (in_range) begin
          addr_d      = quot_q[AddrW-1:0];
          res_index_d = quot_q[pdh_pkg::IndexW-1:0];
        end else begin
          res_oor_d = 1'b1;
        end
      end
      pdh_pkg::StUpdate: res_value_d = (req_q == pdh_pkg::ReqAtom) ? bin_inc : mem_rdata_q;
      default: ;
    endcase
  end

  // output register
  always_comb begin
    out_valid_d  = out_valid_q;
    out_index_d  = out_index_q;
    out_value_d  = out_value_q;
    out_frames_d = out_frames_q;
    out_oor_d    = out_oor_q;
    if (out_load) begin
      out_valid_d  = 1'b1;
      out_index_d  = res_index_q;
      out_value_d  = res_value_q;
      out_frames_d = frame_q;
      out_oor_d    = res_oor_q;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pdh_pkg::StClear;
      axis_q      <= pdh_pkg::AxisX;
      box_low_q   <= '0;
      bin_pitch_q <= 31'd65536;
      bin_count_q <= 11'd64;
      req_q       <= pdh_pkg::ReqAtom;
      step_q      <= '0;
      addr_q      <= '0;
      frame_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      axis_q      <= axis_d;
      box_low_q   <= box_low_d;
      bin_pitch_q <= bin_pitch_d;
      bin_count_q <= bin_count_d;
      req_q       <= req_d;
      step_q      <= step_d;
      addr_q      <= addr_d;
      frame_q     <= frame_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q        <= rem_d;
    quot_q       <= quot_d;
    res_index_q  <= res_index_d;
    res_value_q  <= res_value_d;
    res_oor_q    <= res_oor_d;
    out_index_q  <= out_index_d;
    out_value_q  <= out_value_d;
    out_frames_q <= out_frames_d;
    out_oor_q    <= out_oor_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[addr_q] <= mem_wdata;
    mem_rdata_q <= mem[addr_q];
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'd0, out_frames_q, out_value_q, out_index_q};
  assign m_axis_tuser  = out_oor_q;

  a_no_accept_in_clear : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == pdh_pkg::StClear) |-> !in_accept)
    else $error("beat accepted during bin clear");

  a_drop_result_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> (out_index_q == '0 && out_value_q == '0))
    else $error("dropped atom carries a bin index or count");

  a_frames_monotonic : assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> (frame_q >= $past(frame_q)))
    else $error("frame count went backwards");

  a_bin_update_sat : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == pdh_pkg::StUpdate && mem_we) |->
      (mem_wdata == mem_rdata_q + 1'b1 || mem_rdata_q == CountMax))
    else $error("bin update is not a saturating increment");

  a_div_to_check : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == pdh_pkg::StDiv && step_q == '0) |=> (state_q == pdh_pkg::StCheck))
    else $error("divider did not finish after its last step");

endmodule
